// ===== src/salu_pkg.sv =====
// shared constants, codes and helpers of the stack alu with rotate
package salu_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int DEPTH_W     = 11;
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_MUL  = 3'd2,
		CMD_MOD  = 3'd3,
		CMD_ROTL = 3'd4,
		CMD_ROTR = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FEW     = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// circular slot: base plus offset, offset at most the depth
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
			input logic [CNT_W-1:0] offset);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
		if (sum >= (CNT_W+1)'(STACK_DEPTH)) begin
			sum = sum - (CNT_W+1)'(STACK_DEPTH);
		end
		return PTR_W'(sum);
	endfunction

endpackage

// ===== src/stack_alu_with_rotate.sv =====
// stack alu with rotate: bounded circular stack of 32-bit integers in a ram
//
// Input channel in_valid/in_ready carries one item: cmd and push_value.
// Output channel out_valid/out_ready returns one result per item: status,
// top_value (top entry after the command, zero when empty) and depth.
// Items are handled one at a time; in_ready is high only while idle.
// Path through the states: push, errors, unused codes and short rotations
// go through decode to finish; sub, rotl and rotr through decode and exec;
// mul adds a multiply and a writeback state; mod adds the one bit per cycle
// restoring divider and writeback. The next item is accepted back in idle.
// The stack lies in one ram with a registered read; the top entry
// is also held in a register.
// The result sits in an output register; a new item is accepted while it
// waits, and that item finishes only once the old result has been taken.
// Reset empties the stack (count and bottom pointer cleared); the ram itself
// is not cleared, since no entry is read before it is written.
module stack_alu_with_rotate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          cmd,
	input  logic signed [salu_pkg::DATA_W-1:0]  push_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic signed [salu_pkg::DATA_W-1:0]  top_value,
	output logic [salu_pkg::DEPTH_W-1:0]        depth
);

	import salu_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_WB,
		S_FINISH
	} state_t;

	state_t              state_q;
	logic [2:0]          cmd_q;
	logic [DATA_W-1:0]   val_q;
	logic [DATA_W-1:0]   top_q;
	logic [CNT_W-1:0]    count_q;
	logic [PTR_W-1:0]    bot_q;
	status_t             status_q;
	logic [DATA_W-1:0]   res_q;
	logic [DATA_W-1:0]   mul_a_q;
	logic [DATA_W-1:0]   mul_b_q;
	logic [DATA_W-1:0]   rem_q;
	logic [DATA_W-1:0]   dvd_q;
	logic [DATA_W-1:0]   dsr_q;
	logic                neg_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic                wr_en;
	logic [PTR_W-1:0]    wr_addr;
	logic [DATA_W-1:0]   wr_data;
	logic [PTR_W-1:0]    rd_addr;
	logic [DATA_W-1:0]   rd_data;

	logic [PTR_W-1:0]    second_slot;
	logic [PTR_W-1:0]    next_slot;
	logic [PTR_W-1:0]    rotl_bot;
	logic [PTR_W-1:0]    rotr_bot;
	logic [DATA_W-1:0]   diff;
	logic [DATA_W:0]     trial;
	logic [DATA_W-1:0]   rem_next;
	logic                few;

	salu_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign second_slot = slot_of(bot_q, count_q - CNT_W'(2));
	assign next_slot   = slot_of(bot_q, count_q);
	assign rotl_bot    = slot_of(bot_q, CNT_W'(STACK_DEPTH - 1));
	assign rotr_bot    = slot_of(bot_q, CNT_W'(1));
	assign diff        = rd_data - top_q;
	assign few         = (count_q < CNT_W'(2));
	assign trial       = {rem_q, dvd_q[DATA_W-1]} - {1'b0, dsr_q};
	assign rem_next    = trial[DATA_W] ? {rem_q[DATA_W-2:0], dvd_q[DATA_W-1]}
	                                   : trial[DATA_W-1:0];
	assign rd_addr     = (cmd_q == CMD_ROTR) ? bot_q : second_slot;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = second_slot;
		wr_data = res_q;
		case (state_q)
			S_DECODE: begin
				wr_addr = next_slot;
				wr_data = val_q;
				wr_en   = (cmd_q == CMD_PUSH) && (count_q != CNT_W'(STACK_DEPTH));
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_SUB: begin
						wr_en   = 1'b1;
						wr_data = diff;
					end
					CMD_ROTL: begin
						wr_en   = 1'b1;
						wr_addr = rotl_bot;
						wr_data = top_q;
					end
					CMD_ROTR: begin
						wr_en   = 1'b1;
						wr_addr = next_slot;
						wr_data = rd_data;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			S_WB: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			bot_q     <= '0;
			status_q  <= ST_OK;
			out_valid <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (out_valid && out_ready && state_q != S_FINISH) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q    <= cmd;
						val_q    <= push_value;
						status_q <= ST_OK;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FINISH;
					case (cmd_q)
						CMD_PUSH: begin
							if (count_q == CNT_W'(STACK_DEPTH)) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CNT_W'(1);
								top_q   <= val_q;
							end
						end
						CMD_SUB, CMD_MUL, CMD_MOD: begin
							if (few) begin
								status_q <= ST_FEW;
							end else if (cmd_q == CMD_MOD && top_q == '0) begin
								status_q <= ST_DIVZERO;
							end else begin
								state_q <= S_EXEC;
							end
						end
						CMD_ROTL, CMD_ROTR: begin
							if (!few) begin
								state_q <= S_EXEC;
							end
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_EXEC: begin
					state_q <= S_FINISH;
					case (cmd_q)
						CMD_SUB: begin
							count_q <= count_q - CNT_W'(1);
							top_q   <= diff;
						end
						CMD_MUL: begin
							mul_a_q <= rd_data;
							mul_b_q <= top_q;
							state_q <= S_MUL;
						end
						CMD_MOD: begin
							rem_q     <= '0;
							dvd_q     <= rd_data[DATA_W-1] ? (DATA_W'(0) - rd_data) : rd_data;
							dsr_q     <= top_q[DATA_W-1] ? (DATA_W'(0) - top_q) : top_q;
							neg_q     <= rd_data[DATA_W-1];
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end
						CMD_ROTL: begin
							bot_q <= rotl_bot;
							top_q <= rd_data;
						end
						CMD_ROTR: begin
							bot_q <= rotr_bot;
							top_q <= rd_data;
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_MUL: begin
					res_q   <= mul_a_q * mul_b_q;
					state_q <= S_WB;
				end
				S_DIV: begin
					rem_q     <= rem_next;
					dvd_q     <= {dvd_q[DATA_W-2:0], 1'b0};
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
						res_q   <= neg_q ? (DATA_W'(0) - rem_next) : rem_next;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					count_q <= count_q - CNT_W'(1);
					top_q   <= res_q;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						status    <= status_q;
						top_value <= (count_q == '0) ? '0 : top_q;
						depth     <= DEPTH_W'(count_q);
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/salu_ram.sv =====
// generic single write port, single read port ram with registered read
module salu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
